@@ hdl/asx_pkg.sv @@
// Package: shared types and codes for the ARM-subset execute stage.
`default_nettype none
package asx_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned NumRegs = 15;
  localparam int unsigned BrShift = 2;
  localparam int unsigned BrSignBit = 23;

  localparam logic [2:0] MODE_DP = 3'd0;
  localparam logic [2:0] MODE_MUL = 3'd1;
  localparam logic [2:0] MODE_LS = 3'd2;
  localparam logic [2:0] MODE_BR = 3'd3;
  localparam logic [2:0] MODE_HALT = 3'd4;
  localparam logic [2:0] MODE_LRET = 3'd5;

  localparam logic [3:0] COND_EQ = 4'd0;
  localparam logic [3:0] COND_NE = 4'd1;
  localparam logic [3:0] COND_GE = 4'd10;
  localparam logic [3:0] COND_LT = 4'd11;
  localparam logic [3:0] COND_GT = 4'd12;
  localparam logic [3:0] COND_LE = 4'd13;
  localparam logic [3:0] COND_AL = 4'd14;

  localparam logic [3:0] OP_AND = 4'd0;
  localparam logic [3:0] OP_EOR = 4'd1;
  localparam logic [3:0] OP_SUB = 4'd2;
  localparam logic [3:0] OP_RSB = 4'd3;
  localparam logic [3:0] OP_ADD = 4'd4;
  localparam logic [3:0] OP_TST = 4'd8;
  localparam logic [3:0] OP_TEQ = 4'd9;
  localparam logic [3:0] OP_CMP = 4'd10;
  localparam logic [3:0] OP_ORR = 4'd12;
  localparam logic [3:0] OP_MOV = 4'd13;

  localparam logic [1:0] SH_LSL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ASR = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;

  // listed from the top bit down, so the packed layout is the input tdata layout
  typedef struct packed {
    logic [31:0] pc_value;
    logic [31:0] operand;
    logic [3:0]  dest_reg;
    logic [3:0]  base_reg;
    logic        load;
    logic        add_offset;
    logic        pre_index;
    logic        imm_flag;
    logic        set_flags;
    logic [3:0]  opcode;
    logic [3:0]  cond;
    logic [2:0]  mode;
  } instr_t;

  typedef struct packed {
    logic        executed;
    logic        branch_taken;
    logic [31:0] branch_target;
    logic        mem_valid;
    logic        mem_write;
    logic [31:0] mem_address;
    logic        halted;
    logic [31:0] store_data;
    logic [3:0]  flags_out;
  } result_t;

  // register-file write request
  typedef struct packed {
    logic        en;
    logic [3:0]  idx;
    logic [31:0] data;
  } wr_port_t;

endpackage
`default_nettype wire

@@ hdl/arm_subset_execute_stage_unit.sv @@
// Top level: ARM-subset execute stage with streaming ports.
// The result is registered and valid in the cycle after input acceptance.
// Throughput: one item per cycle; the state update and result are one pass of logic.
// A full output register stalls input until the result is taken or replaced.
// Reset (rst_n low, synchronous) clears r0..r14, the flags, load-pending state,
// and the output valid.
`default_nettype none
module arm_subset_execute_stage_unit #(
  parameter int unsigned NREGS = asx_pkg::NumRegs
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // mode[2:0] cond[6:3] opcode[10:7] set_flags[11] imm_flag[12] pre_index[13]
  // add_offset[14] load[15] base_reg[19:16] dest_reg[23:20] operand[55:24]
  // pc_value[87:56]
  input  wire logic [87:0]  in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // executed[0] branch_taken[1] branch_target[33:2] mem_valid[34] mem_write[35]
  // mem_address[67:36] store_data[99:68] halted[100] flags_out[104:101], zero pad
  output logic [111:0]      out_tdata
);
  import asx_pkg::*;

  instr_t  ins;
  result_t res;
  logic    fire;
  logic    ov_r;
  logic [104:0] od_r;

  assign ins = '{mode: in_tdata[2:0], cond: in_tdata[6:3], opcode: in_tdata[10:7],
                 set_flags: in_tdata[11], imm_flag: in_tdata[12], pre_index: in_tdata[13],
                 add_offset: in_tdata[14], load: in_tdata[15], base_reg: in_tdata[19:16],
                 dest_reg: in_tdata[23:20], operand: in_tdata[55:24],
                 pc_value: in_tdata[87:56]};

  assign in_tready = !ov_r || out_tready;
  assign fire = in_tvalid && in_tready;

  asx_core #(.NREGS(NREGS)) u_core (.clk(clk), .rst_n(rst_n), .fire(fire), .ins(ins), .res(res));

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (in_tready) ov_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (fire)
      od_r <= {res.flags_out, res.halted, res.store_data, res.mem_address, res.mem_write,
               res.mem_valid, res.branch_target, res.branch_taken, res.executed};
  end

  assign out_tvalid = ov_r;
  assign out_tdata = {7'd0, od_r};
endmodule
`default_nettype wire

@@ hdl/asx_shifter.sv @@
// Barrel shifter with ARM shifter carry-out.
`default_nettype none
module asx_shifter (
  input  wire logic [31:0] val,
  input  wire logic [1:0]  sh_type,
  input  wire logic [7:0]  amt,
  input  wire logic        cin,
  output logic [31:0]      res,
  output logic             cout
);
  import asx_pkg::*;

  logic [4:0]  a5;
  logic        big;
  logic [63:0] ext;

  always_comb begin
    a5 = amt[4:0];
    big = (amt[7:5] != 3'd0);
    ext = 64'd0;
    res = val;
    cout = cin;
    if (amt != 8'd0) begin
      case (sh_type)
        SH_LSL: begin
          if (!big) begin
            ext = {32'd0, val} << a5;
            res = ext[31:0];
            cout = ext[32];
          end else begin
            res = 32'd0;
            cout = (amt == 8'd32) ? val[0] : 1'b0;
          end
        end
        SH_LSR: begin
          if (!big) begin
            ext = {val, 32'd0} >> a5;
            res = ext[63:32];
            cout = ext[31];
          end else begin
            res = 32'd0;
            cout = (amt == 8'd32) ? val[31] : 1'b0;
          end
        end
        SH_ASR: begin
          if (!big) begin
            ext = $unsigned($signed({val, 32'd0}) >>> a5);
            res = ext[63:32];
            cout = ext[31];
          end else begin
            res = {32{val[31]}};
            cout = val[31];
          end
        end
        default: begin
          ext = {val, val} >> a5;
          res = ext[31:0];
          cout = res[31];
        end
      endcase
    end
  end
endmodule
`default_nettype wire

@@ hdl/asx_regfile.sv @@
// Register file r0..r14 with four reads, r15 reads as pc, two write ports.
`default_nettype none
module asx_regfile #(
  parameter int unsigned NREGS = asx_pkg::NumRegs
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [3:0]        ra0,
  input  wire logic [3:0]        ra1,
  input  wire logic [3:0]        ra2,
  input  wire logic [3:0]        ra3,
  input  wire logic [31:0]       pc,
  output logic [31:0]            rd0,
  output logic [31:0]            rd1,
  output logic [31:0]            rd2,
  output logic [31:0]            rd3,
  input  wire asx_pkg::wr_port_t wa,
  input  wire asx_pkg::wr_port_t wb
);
  import asx_pkg::*;

  logic [31:0] regs_r [NREGS];

  function automatic logic [31:0] rd(input logic [3:0] a, input logic [31:0] p,
                                     input logic [31:0] q [NREGS]);
    logic [31:0] v;
    v = p;
    for (int i = 0; i < NREGS; i++)
      if (a == 4'(i)) v = q[i];
    return v;
  endfunction

  assign rd0 = rd(ra0, pc, regs_r);
  assign rd1 = rd(ra1, pc, regs_r);
  assign rd2 = rd(ra2, pc, regs_r);
  assign rd3 = rd(ra3, pc, regs_r);

  // port a wins ties; port b (base write-back) writes a register only when a is not enabled for it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NREGS; i++) regs_r[i] <= 32'd0;
    end else begin
      for (int i = 0; i < NREGS; i++) begin
        if (wa.en && wa.idx == 4'(i)) regs_r[i] <= wa.data;
        else if (wb.en && wb.idx == 4'(i)) regs_r[i] <= wb.data;
      end
    end
  end
endmodule
`default_nettype wire

@@ hdl/asx_core.sv @@
// Execute logic: condition check, ALU, multiply, load/store, branch, halt, load return, state.
`default_nettype none
module asx_core #(
  parameter int unsigned NREGS = asx_pkg::NumRegs
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  wire asx_pkg::instr_t  ins,
  output asx_pkg::result_t      res
);
  import asx_pkg::*;

  logic [3:0]  flags_r, flags_nxt;
  logic        lpend_r, lpend_nxt;
  logic [3:0]  ltgt_r, ltgt_nxt;
  logic [31:0] rn, rm, rs, rdv;
  logic [3:0]  ra1, ra2;
  wr_port_t    wa, wb;
  logic [31:0] sh_out;
  logic        sh_c;
  logic [7:0]  sh_amt;
  logic        pass;
  logic        n, z, c, v;

  assign n = flags_r[3];
  assign z = flags_r[2];
  assign c = flags_r[1];
  assign v = flags_r[0];

  assign ra1 = ins.operand[3:0];
  assign ra2 = ins.operand[11:8];

  asx_regfile #(.NREGS(NREGS)) u_rf (
    .clk(clk), .rst_n(rst_n),
    .ra0(ins.base_reg), .ra1(ra1), .ra2(ra2), .ra3(ins.dest_reg),
    .pc(ins.pc_value),
    .rd0(rn), .rd1(rm), .rd2(rs), .rd3(rdv),
    .wa(wa), .wb(wb)
  );

  assign sh_amt = ins.operand[4] ? rs[7:0] : {3'd0, ins.operand[11:7]};

  asx_shifter u_sh (
    .val(rm), .sh_type(ins.operand[6:5]), .amt(sh_amt), .cin(c),
    .res(sh_out), .cout(sh_c)
  );

  // condition evaluation
  always_comb begin
    case (ins.cond)
      COND_EQ: pass = z;
      COND_NE: pass = !z;
      COND_GE: pass = (n == v);
      COND_LT: pass = (n != v);
      COND_GT: pass = !z && (n == v);
      COND_LE: pass = z || (n != v);
      COND_AL: pass = 1'b1;
      default: pass = 1'b0;
    endcase
  end

  logic [31:0] op2, alu, mul, off, moved, rot_v;
  logic [63:0] rot_e;
  logic        cnew, valid, wbk;
  logic [32:0] sum;

  always_comb begin
    res = '0;
    wa = '0;
    wb = '0;
    flags_nxt = flags_r;
    lpend_nxt = lpend_r;
    ltgt_nxt = ltgt_r;
    rot_e = {24'd0, ins.operand[7:0], 24'd0, ins.operand[7:0]} >> {ins.operand[11:8], 1'b0};
    rot_v = rot_e[31:0];
    op2 = 32'd0;
    cnew = c;
    alu = 32'd0;
    valid = 1'b1;
    wbk = 1'b1;
    sum = 33'd0;
    mul = rm * rs;
    off = 32'd0;
    moved = 32'd0;
    if (ins.mode == MODE_HALT) begin
      res.halted = 1'b1;
      res.executed = 1'b1;
    end else if (ins.mode == MODE_LRET) begin
      if (lpend_r) begin
        wa = '{en: (ltgt_r != 4'd15), idx: ltgt_r, data: ins.operand};
        lpend_nxt = 1'b0;
        res.executed = 1'b1;
      end
    end else if (ins.mode <= MODE_BR && pass) begin
      res.executed = 1'b1;
      case (ins.mode)
        MODE_DP: begin
          if (ins.imm_flag) begin
            op2 = rot_v;
            if (ins.operand[11:8] != 4'd0) cnew = rot_v[31];
          end else begin
            op2 = sh_out;
            cnew = sh_c;
          end
          case (ins.opcode)
            OP_AND: alu = rn & op2;
            OP_TST: begin alu = rn & op2; wbk = 1'b0; end
            OP_EOR: alu = rn ^ op2;
            OP_TEQ: begin alu = rn ^ op2; wbk = 1'b0; end
            OP_SUB: begin sum = {1'b0, rn} - {1'b0, op2}; alu = sum[31:0]; cnew = !sum[32]; end
            OP_CMP: begin
              sum = {1'b0, rn} - {1'b0, op2}; alu = sum[31:0]; cnew = !sum[32]; wbk = 1'b0;
            end
            OP_RSB: begin sum = {1'b0, op2} - {1'b0, rn}; alu = sum[31:0]; cnew = !sum[32]; end
            OP_ADD: begin sum = {1'b0, rn} + {1'b0, op2}; alu = sum[31:0]; cnew = sum[32]; end
            OP_ORR: alu = rn | op2;
            OP_MOV: alu = op2;
            default: valid = 1'b0;
          endcase
          if (valid) begin
            if (ins.set_flags) flags_nxt = {alu[31], alu == 32'd0, cnew, v};
            if (wbk) wa = '{en: (ins.dest_reg != 4'd15), idx: ins.dest_reg, data: alu};
          end
        end
        MODE_MUL: begin
          if (ins.opcode[0]) mul = mul + rn;
          if (ins.set_flags) flags_nxt = {mul[31], mul == 32'd0, c, v};
          wa = '{en: (ins.dest_reg != 4'd15), idx: ins.dest_reg, data: mul};
        end
        MODE_LS: begin
          off = ins.imm_flag ? sh_out : {20'd0, ins.operand[11:0]};
          moved = ins.add_offset ? rn + off : rn - off;
          res.mem_valid = 1'b1;
          res.mem_address = ins.pre_index ? moved : rn;
          if (ins.load) begin
            lpend_nxt = 1'b1;
            ltgt_nxt = ins.dest_reg;
          end else begin
            res.mem_write = 1'b1;
            res.store_data = rdv;
          end
          if (!ins.pre_index)
            wb = '{en: (ins.base_reg != 4'd15), idx: ins.base_reg, data: moved};
        end
        default: begin
          res.branch_taken = 1'b1;
          res.branch_target = ins.pc_value +
            ({{(32-BrSignBit-1){ins.operand[BrSignBit]}}, ins.operand[BrSignBit:0]} << BrShift);
        end
      endcase
    end
    res.flags_out = flags_nxt;
    if (!fire) begin
      wa.en = 1'b0;
      wb.en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= 4'd0;
      lpend_r <= 1'b0;
      ltgt_r <= 4'd0;
    end else if (fire) begin
      flags_r <= flags_nxt;
      lpend_r <= lpend_nxt;
      ltgt_r <= ltgt_nxt;
    end
  end

  // a load return never leaves a load pending
  assert property (@(posedge clk) disable iff (!rst_n)
    fire && ins.mode == MODE_LRET |=> !lpend_r) else $error("pending after return");
  // a load request records its destination
  assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.mem_valid && !res.mem_write |=> lpend_r && ltgt_r == $past(ins.dest_reg))
    else $error("load target lost");
  // flags only change on an accepted item
  assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(flags_r)) else $error("flags changed while idle");
endmodule
`default_nettype wire
